>>> design/assert_macros.svh
// Assertion macros for the checker file of this block, pcrc_checker.sv.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked at every clock, off while reset is asserted.
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

>>> design/pcrc_pkg.sv
// Package for the programmable serial CRC: configuration type, register
// indexes, input kinds and size constants. No dependencies.
package pcrc_pkg;

	localparam int unsigned MaxDegreeDefault = 16;
	localparam int unsigned GenWidth         = 16;
	localparam int unsigned DegWidth         = 5;
	localparam int unsigned CfgIdxWidth      = 2;
	localparam int unsigned CfgDataWidth     = 16;

	typedef enum logic [CfgIdxWidth-1:0] {
		REG_GENERATOR = 2'd0,
		REG_DEGREE    = 2'd1,
		REG_CHECK     = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_BIT    = 1'b0,
		KIND_FINISH = 1'b1
	} item_kind_t;

	typedef struct packed {
		logic [GenWidth-1:0] generator_low_bits;
		logic [DegWidth-1:0] degree;
		logic                check_mode;
	} cfg_t;

endpackage

>>> design/programmable_crc_serial.sv
// Top level of the programmable serial CRC: configuration registers,
// divider and result emitter. Depends on pcrc_pkg, pcrc_divider, pcrc_emitter.
//
//   channel   direction  payload
//   s_axis    in         tdata[0] bit_in; tuser[0] kind
//   m_axis    out        tdata[0] remainder_bit; tlast last; tuser[0] remainder_zero
//   cfg       in         cfg_index selects register, cfg_data value, cfg_we strobe
//
// A message bit is held in the input register; one bit per cycle is
// sustained, also while a remainder is being sent.
// A finish holds the input register until the emitter is empty, then gives
// degree result bits, one per cycle while the receiver is ready; a new finish
// waits until the single emitter shift register has sent the previous remainder.
// Reset clears the remainder and restores degree 1, generate mode.
module programmable_crc_serial #(
	parameter int unsigned MAX_DEGREE = pcrc_pkg::MaxDegreeDefault
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,  // [0] bit_in
	input  logic [0:0]                          s_axis_tuser,  // [0] kind
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [7:0]                          m_axis_tdata,  // [0] remainder_bit
	output logic                                m_axis_tlast,
	output logic [0:0]                          m_axis_tuser,  // [0] remainder_zero
	input  logic                                cfg_we,
	input  logic [pcrc_pkg::CfgIdxWidth-1:0]    cfg_index,
	input  logic [pcrc_pkg::CfgDataWidth-1:0]   cfg_data
);
	import pcrc_pkg::*;

	localparam int unsigned DW = $clog2(MAX_DEGREE + 1);

	cfg_t                  cfg_q;
	logic                  fin_valid;
	logic                  fin_ready;
	logic [MAX_DEGREE-1:0] fin_snap;
	logic                  fin_zero;
	logic [DW-1:0]         fin_count;
	logic                  out_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.generator_low_bits <= '0;
			cfg_q.degree             <= DegWidth'(1);
			cfg_q.check_mode         <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GENERATOR: cfg_q.generator_low_bits <= cfg_data[GenWidth-1:0];
				REG_DEGREE:    cfg_q.degree             <= cfg_data[DegWidth-1:0];
				REG_CHECK:     cfg_q.check_mode         <= cfg_data[0];
				default:       cfg_q                    <= cfg_q;
			endcase
		end
	end

	pcrc_divider #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser[0]),
		.in_bit    (s_axis_tdata[0]),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin_snap  (fin_snap),
		.fin_zero  (fin_zero),
		.fin_count (fin_count)
	);

	pcrc_emitter #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (fin_valid),
		.load_ready (fin_ready),
		.load_snap  (fin_snap),
		.load_zero  (fin_zero),
		.load_count (fin_count),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_bit    (out_bit),
		.out_last   (m_axis_tlast),
		.out_zero   (m_axis_tuser[0])
	);

	assign m_axis_tdata = {7'b0, out_bit};

endmodule

>>> design/pcrc_divider.sv
// Input register and remainder update for the programmable serial CRC.
// Depends on pcrc_pkg. Hands a left-aligned remainder snapshot to the emitter.
module pcrc_divider #(
	parameter int unsigned MAX_DEGREE = pcrc_pkg::MaxDegreeDefault,
	localparam int unsigned DW = $clog2(MAX_DEGREE + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pcrc_pkg::cfg_t        cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_kind,
	input  logic                  in_bit,
	output logic                  fin_valid,
	input  logic                  fin_ready,
	output logic [MAX_DEGREE-1:0] fin_snap,
	output logic                  fin_zero,
	output logic [DW-1:0]         fin_count
);
	import pcrc_pkg::*;

	localparam int unsigned IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

	logic                  valid_s1;
	logic                  kind_s1;
	logic                  bit_s1;
	logic [MAX_DEGREE-1:0] rem_q;

	logic [5:0]            deg6;
	logic [DW-1:0]         d_eff;
	logic [MAX_DEGREE-1:0] mask;
	logic [31:0]           gen32;
	logic [MAX_DEGREE-1:0] gen_m;
	logic [MAX_DEGREE-1:0] rem_m;
	logic [IW-1:0]         top_idx;
	logic                  top;
	logic [MAX_DEGREE-1:0] rem_nxt;
	logic                  retire;
	logic                  is_finish;

	// Clamp degree into 1..MAX_DEGREE.
	always_comb begin
		deg6 = {1'b0, cfg.degree};
		if (deg6 == 6'd0) begin
			d_eff = DW'(1);
		end else if (deg6 > 6'(MAX_DEGREE)) begin
			d_eff = DW'(MAX_DEGREE);
		end else begin
			d_eff = DW'(deg6);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_DEGREE; i++) begin
			mask[i] = ((DW + 1)'(i) < {1'b0, d_eff});
		end
	end

	assign gen32   = {16'b0, cfg.generator_low_bits};
	assign gen_m   = gen32[MAX_DEGREE-1:0] & mask;
	assign rem_m   = rem_q & mask;
	assign top_idx = IW'(d_eff - DW'(1));
	assign top     = rem_m[top_idx];

	always_comb begin
		if (!cfg.check_mode) begin
			rem_nxt = ((rem_m << 1) & mask) ^ ((top ^ bit_s1) ? gen_m : '0);
		end else begin
			rem_nxt = ((rem_m << 1) | MAX_DEGREE'(bit_s1)) & mask;
			rem_nxt = rem_nxt ^ (top ? gen_m : '0);
		end
	end

	assign is_finish = (item_kind_t'(kind_s1) == KIND_FINISH);
	assign fin_valid = valid_s1 && is_finish;
	assign retire    = valid_s1 && (!is_finish || fin_ready);
	assign in_ready  = !valid_s1 || retire;

	assign fin_snap  = rem_m << (DW'(MAX_DEGREE) - d_eff);
	assign fin_zero  = (rem_m == '0);
	assign fin_count = d_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= in_kind;
			bit_s1  <= in_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (retire) begin
			rem_q <= is_finish ? '0 : rem_nxt;
		end
	end

endmodule

>>> design/pcrc_emitter.sv
// Result shifter for the programmable serial CRC: sends a remainder snapshot
// out one bit per request, most significant first. Depends on pcrc_pkg.
module pcrc_emitter #(
	parameter int unsigned MAX_DEGREE = pcrc_pkg::MaxDegreeDefault,
	localparam int unsigned DW = $clog2(MAX_DEGREE + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load_valid,
	output logic                  load_ready,
	input  logic [MAX_DEGREE-1:0] load_snap,
	input  logic                  load_zero,
	input  logic [DW-1:0]         load_count,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  out_bit,
	output logic                  out_last,
	output logic                  out_zero
);
	import pcrc_pkg::*;

	logic [DW-1:0]         cnt_q;
	logic [MAX_DEGREE-1:0] shreg_q;
	logic                  zero_q;

	assign load_ready = (cnt_q == '0);
	assign out_valid  = (cnt_q != '0);
	assign out_bit    = shreg_q[MAX_DEGREE-1];
	assign out_last   = (cnt_q == DW'(1));
	assign out_zero   = zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load_valid && load_ready) begin
			cnt_q <= load_count;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - DW'(1);
		end
	end

	// Advance one bit per accepted request.
	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			shreg_q <= load_snap;
			zero_q  <= load_zero;
		end else if (out_valid && out_ready) begin
			shreg_q <= shreg_q << 1;
		end
	end

endmodule

>>> design/pcrc_checker.sv
// Port-level checks for the programmable serial CRC, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pcrc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic [0:0] m_axis_tuser
);

	logic       out_fire;
	logic       out_stall;
	logic [9:0] out_beat;

	assign out_fire  = m_axis_tvalid && m_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_beat  = {m_axis_tdata, m_axis_tlast, m_axis_tuser};

	// A stalled result holds.
	`ASSERT_CLK(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_beat), "stalled result changed")

	// Within one remainder run the next bit follows and the zero flag stays.
	`ASSERT_CLK(a_run_cont, out_fire && !m_axis_tlast |=> m_axis_tvalid && $stable(m_axis_tuser), "run broken")

	// A zero remainder never shows a one bit.
	`ASSERT_IMPL(a_zero_bits, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[0] == 1'b0, "set bit in zero remainder")

	// Once the run ends the input side is open again.
	`ASSERT_CLK(a_free_after, out_fire && m_axis_tlast |=> s_axis_tready, "input blocked after run")

endmodule

bind programmable_crc_serial pcrc_checker u_pcrc_checker (.*);

>>> tb/crc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for programmable_crc_serial: tracks register writes, predicts the
// remainder bits of each finish request and compares them. Depends on pcrc_pkg.
module crc_checker #(
	parameter int unsigned MAX_DEGREE = pcrc_pkg::MaxDegreeDefault
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	input  logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,  // [0] bit_in
	input  logic [0:0]                          s_axis_tuser,  // [0] kind
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic [7:0]                          m_axis_tdata,  // [0] remainder_bit
	input  logic                                m_axis_tlast,
	input  logic [0:0]                          m_axis_tuser,  // [0] remainder_zero
	input  logic                                cfg_we,
	input  logic [pcrc_pkg::CfgIdxWidth-1:0]    cfg_index,
	input  logic [pcrc_pkg::CfgDataWidth-1:0]   cfg_data,
	output int unsigned                         outstanding,
	output int unsigned                         fail_count
);
	import pcrc_pkg::*;

	typedef struct packed {
		logic rem_bit;
		logic last;
		logic zero;
	} crc_beat_t;

	logic [GenWidth-1:0] gen_q;
	logic [DegWidth-1:0] deg_q;
	logic                check_q;
	logic [31:0]         remainder;
	crc_beat_t           expected_beats[$];
	int unsigned         errors;

	// Clamp the programmed degree into 1..MAX_DEGREE.
	function automatic int unsigned active_degree(input logic [DegWidth-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MAX_DEGREE)
			return MAX_DEGREE;
		return raw;
	endfunction

	function automatic logic [31:0] degree_mask(input int unsigned d);
		return (d >= 32) ? 32'hFFFF_FFFF : ((32'd1 << d) - 32'd1);
	endfunction

	// One division step for a message bit under the current settings.
	function automatic logic [31:0] shift_remainder(input logic [31:0] rem, input logic data_bit,
			input int unsigned d);
		logic [31:0] mask;
		logic [31:0] poly;
		logic        top_bit;
		logic [31:0] acc;
		mask    = degree_mask(d);
		poly    = {16'd0, gen_q} & mask;
		acc     = rem & mask;
		top_bit = acc[d-1];
		if (!check_q) begin
			acc = (acc << 1) & mask;
			if (top_bit ^ data_bit)
				acc = acc ^ poly;
		end else begin
			acc = ((acc << 1) | {31'd0, data_bit}) & mask;
			if (top_bit)
				acc = acc ^ poly;
		end
		return acc;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		crc_beat_t   want;
		crc_beat_t   got;
		int unsigned d;
		logic [31:0] rem;
		if (!arst_n) begin
			gen_q     = '0;
			deg_q     = 5'd1;
			check_q   = 1'b0;
			remainder = '0;
			errors    = 0;
			expected_beats.delete();
			outstanding <= 0;
			fail_count  <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[0], m_axis_tlast, m_axis_tuser[0]};
				if (expected_beats.size() == 0) begin
					errors++;
					$display("%0t: unexpected result bit=%b last=%b zero=%b", $time,
						got.rem_bit, got.last, got.zero);
				end else begin
					want = expected_beats.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch expected bit=%b last=%b zero=%b, actual bit=%b last=%b zero=%b",
							$time, want.rem_bit, want.last, want.zero,
							got.rem_bit, got.last, got.zero);
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				d = active_degree(deg_q);
				if (item_kind_t'(s_axis_tuser[0]) == KIND_BIT) begin
					remainder = shift_remainder(remainder, s_axis_tdata[0], d);
				end else begin
					// Emit MSB first, then clear the remainder.
					rem = remainder & degree_mask(d);
					for (int k = d; k > 0; k--)
						expected_beats.push_back({rem[k-1], k == 1, rem == 0});
					remainder = '0;
				end
			end

			// Register writes take effect after any request accepted on this edge.
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_GENERATOR: gen_q = cfg_data[GenWidth-1:0];
					REG_DEGREE:    deg_q = cfg_data[DegWidth-1:0];
					REG_CHECK:     check_q = cfg_data[0];
					default: ;
				endcase
			end

			outstanding <= expected_beats.size();
			fail_count  <= errors;
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for programmable_crc_serial: clock, reset, directed and random
// bit streams, register writes and the verdict. Depends on pcrc_pkg and crc_checker.
module tb_top;
	import pcrc_pkg::*;

	localparam int unsigned RANDOM_ITEMS  = 370;
	localparam int unsigned SETTLE_CYCLES = 8;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [7:0]              s_axis_tdata  = 8'd0;  // [0] bit_in
	logic [0:0]              s_axis_tuser  = 1'b0;  // [0] kind
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [7:0]              m_axis_tdata;          // [0] remainder_bit
	logic                    m_axis_tlast;
	logic [0:0]              m_axis_tuser;          // [0] remainder_zero
	logic                    cfg_we        = 1'b0;
	logic [CfgIdxWidth-1:0]  cfg_index     = REG_GENERATOR;
	logic [CfgDataWidth-1:0] cfg_data      = '0;

	int unsigned outstanding;
	int unsigned fail_count;

	int unsigned         burst_left = 0;
	int unsigned         sent       = 0;
	bit                  gaps_on    = 1'b1;
	logic [GenWidth-1:0] cur_gen    = '0;
	logic [DegWidth-1:0] cur_deg    = 5'd1;
	logic                cur_chk    = 1'b0;
	logic                msg_buf [0:15];

	programmable_crc_serial DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	crc_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.outstanding   (outstanding),
		.fail_count    (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

	// Receiver: stretches of always ready, coin flips, rare ready and toggling.
	initial begin : sink_pattern
		int unsigned mode;
		int unsigned span;
		int unsigned tick;
		tick = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 64);
			repeat (span) begin
				@(posedge clk);
				tick++;
				case (mode)
					0:       m_axis_tready <= 1'b1;
					1:       m_axis_tready <= ($urandom_range(0, 1) != 0);
					2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= tick[0];
				endcase
			end
		end
	end

	// Send one request; insert a random gap at the start of each burst when gaps are on.
	task automatic send_req(input item_kind_t kind, input logic data_bit);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				gap = $urandom_range(1, 6);
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, data_bit};
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		sent++;
	endtask

	// Drop valid, drain all expected results, then let in-flight bits retire.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataWidth-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_GENERATOR: cur_gen = val[GenWidth-1:0];
			REG_DEGREE:    cur_deg = val[DegWidth-1:0];
			REG_CHECK:     cur_chk = val[0];
			default: ;
		endcase
	endtask

	initial begin : stimulus
		int unsigned pick;
		int unsigned len;
		int unsigned d;
		int          flip;
		logic [15:0] crc;
		logic [15:0] mask;
		logic        fb;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Finish with no message bits at the reset degree, then a short message.
		send_req(KIND_FINISH, 1'b0);
		send_req(KIND_BIT, 1'b1);
		send_req(KIND_BIT, 1'b0);
		send_req(KIND_FINISH, 1'b1);

		// Degree zero acts as one; generator bits above the degree are ignored.
		settle();
		write_reg(REG_DEGREE, 16'd0);
		write_reg(REG_GENERATOR, 16'hFFFF);
		send_req(KIND_BIT, 1'b1);
		send_req(KIND_FINISH, 1'b0);

		// Degree above the maximum clamps.
		settle();
		write_reg(REG_DEGREE, 16'd31);
		send_req(KIND_BIT, 1'b1);
		send_req(KIND_BIT, 1'b1);
		send_req(KIND_FINISH, 1'b0);

		settle();
		write_reg(REG_GENERATOR, 16'h1021);
		write_reg(REG_DEGREE, 16'd16);
		write_reg(REG_CHECK, 16'd1);
		send_req(KIND_BIT, 1'b1);
		send_req(KIND_FINISH, 1'b1);

		// Change every register partway through a message.
		settle();
		write_reg(REG_CHECK, 16'd0);
		write_reg(REG_DEGREE, 16'd8);
		write_reg(REG_GENERATOR, 16'h0007);
		send_req(KIND_BIT, 1'b1);
		send_req(KIND_BIT, 1'b1);
		send_req(KIND_BIT, 1'b0);
		send_req(KIND_BIT, 1'b1);
		settle();
		write_reg(REG_DEGREE, 16'd4);
		write_reg(REG_GENERATOR, 16'h0003);
		write_reg(REG_CHECK, 16'd1);
		send_req(KIND_BIT, 1'b1);
		send_req(KIND_BIT, 1'b0);
		send_req(KIND_FINISH, 1'b0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			pick    = $urandom_range(0, 15);
			if (pick == 0) begin
				settle();
				pick = $urandom_range(0, 9);
				write_reg(REG_GENERATOR, (pick == 0) ? 16'h0000 :
					(pick == 1) ? 16'hFFFF : 16'($urandom));
				pick = $urandom_range(0, 19);
				if (pick == 0)
					write_reg(REG_DEGREE, 16'd0);
				else if (pick == 1)
					write_reg(REG_DEGREE, 16'($urandom_range(17, 31)));
				else if (pick < 5)
					write_reg(REG_DEGREE, 16'd16);
				else if (pick < 8)
					write_reg(REG_DEGREE, 16'($urandom_range(9, 15)));
				else
					write_reg(REG_DEGREE, 16'($urandom_range(1, 8)));
				write_reg(REG_CHECK, 16'($urandom_range(0, 1)));
			end else if (pick < 9) begin
				len = $urandom_range(1, 24);
				repeat (len) send_req(KIND_BIT, $urandom_range(0, 1) != 0);
				send_req(KIND_FINISH, $urandom_range(0, 1) != 0);
			end else if (pick < 12) begin
				// Codeword: message then its CRC, sometimes with one bit flipped.
				if (!cur_chk) begin
					settle();
					write_reg(REG_CHECK, 16'd1);
				end
				d    = (cur_deg == 0) ? 1 : (cur_deg > MaxDegreeDefault) ?
					MaxDegreeDefault : cur_deg;
				mask = 16'((32'd1 << d) - 32'd1);
				len  = $urandom_range(1, 16);
				crc  = '0;
				for (int i = 0; i < len; i++) begin
					msg_buf[i] = $urandom_range(0, 1) != 0;
					fb  = crc[d-1] ^ msg_buf[i];
					crc = (crc << 1) & mask;
					if (fb)
						crc = crc ^ (cur_gen & mask);
				end
				flip = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, len + d - 1)) : -1;
				for (int i = 0; i < len; i++)
					send_req(KIND_BIT, msg_buf[i] ^ (i == flip));
				for (int k = 0; k < d; k++)
					send_req(KIND_BIT, crc[d-1-k] ^ (len + k == flip));
				send_req(KIND_FINISH, $urandom_range(0, 1) != 0);
			end else if (pick < 14) begin
				repeat ($urandom_range(1, 8))
					send_req(item_kind_t'($urandom_range(0, 1)), $urandom_range(0, 1) != 0);
			end else begin
				repeat ($urandom_range(1, 3))
					send_req(KIND_FINISH, $urandom_range(0, 1) != 0);
			end
		end

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
